// ===== rtl/mctm_pkg.sv =====
// Shared constants, types and helper functions of the multi-channel timeout monitor.
`default_nettype none

package mctm_pkg;

    // Table size and stamp arithmetic width.
    localparam int NUM_CHANNELS = 16;
    localparam int STAMP_BITS   = 48;

    // Fixed widths of the item fields.
    localparam int ReqW        = 4;
    localparam int ChanW       = 4;
    localparam int StampFieldW = 48;
    localparam int StatusW     = 2;

    // Derived sizes.
    localparam int ChW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MaxRes     = 16;
    localparam int CntW       = $clog2(MaxRes + 1);
    localparam int QueueDepth = 2;
    localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Request codes as they arrive on the input channel.
    localparam logic [ReqW-1:0] REQ_TICK      = 4'd0;
    localparam logic [ReqW-1:0] REQ_ALLOC     = 4'd1;
    localparam logic [ReqW-1:0] REQ_RELEASE   = 4'd2;
    localparam logic [ReqW-1:0] REQ_START     = 4'd3;
    localparam logic [ReqW-1:0] REQ_PAUSE     = 4'd4;
    localparam logic [ReqW-1:0] REQ_KICK      = 4'd5;
    localparam logic [ReqW-1:0] REQ_SET_TMO   = 4'd6;
    localparam logic [ReqW-1:0] REQ_START_ALL = 4'd7;
    localparam logic [ReqW-1:0] REQ_PAUSE_ALL = 4'd8;

    // Result status codes.
    localparam logic [StatusW-1:0] ST_OK         = 2'd0;
    localparam logic [StatusW-1:0] ST_NOT_IN_USE = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL       = 2'd2;

    // Decoded operation carried from the front end to the execution unit.
    typedef enum logic [3:0] {
        OP_TICK,
        OP_ALLOC,
        OP_RELEASE,
        OP_START,
        OP_PAUSE,
        OP_KICK,
        OP_SET_TMO,
        OP_START_ALL,
        OP_PAUSE_ALL,
        OP_NOP
    } t_op;

    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [ChW-1:0]        t_chan;

    // Classified command as held in the queue.
    typedef struct packed {
        t_op              op;
        logic [ChanW-1:0] chan_field;
        t_chan            chan;
        logic             chan_ok;
        t_stamp           now;
        t_stamp           tmo;
        logic             oneshot;
        logic             start;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [ChanW-1:0]       out_channel;
        logic [StampFieldW-1:0] reset_stamp;
        logic                   fired;
        logic [StatusW-1:0]     status;
        logic                   last_result;
    } t_res;

    // Reduce a field value to the stamp width (or widen it with zeros).
    function automatic t_stamp to_stamp(input logic [StampFieldW-1:0] x);
        logic [StampFieldW+63:0] w;
        w = {64'd0, x};
        return w[STAMP_BITS-1:0];
    endfunction

    // Bring a stored stamp back to the field width.
    function automatic logic [StampFieldW-1:0] from_stamp(input t_stamp s);
        logic [STAMP_BITS+63:0] w;
        w = {64'd0, s};
        return w[StampFieldW-1:0];
    endfunction

    // Channel index to the 4-bit field, taken modulo the field range.
    function automatic logic [ChanW-1:0] chan_field(input t_chan c);
        logic [ChW+ChanW-1:0] w;
        w = {{ChanW{1'b0}}, c};
        return w[ChanW-1:0];
    endfunction

    // Channel field to a table index.
    function automatic t_chan to_chan(input logic [ChanW-1:0] f);
        logic [ChW+ChanW-1:0] w;
        w = {{ChW{1'b0}}, f};
        return w[ChW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mctm_if.sv =====
// Valid/ready channel interfaces for the request and result items.
`default_nettype none

interface mctm_req_if;
    logic                                valid;
    logic                                ready;
    logic [mctm_pkg::ReqW-1:0]           req_type;
    logic [mctm_pkg::ChanW-1:0]          channel;
    logic [mctm_pkg::StampFieldW-1:0]    now_stamp;
    logic [mctm_pkg::StampFieldW-1:0]    timeout_value;
    logic                                oneshot_flag;
    logic                                start_flag;

    modport source (
        output valid, req_type, channel, now_stamp, timeout_value, oneshot_flag, start_flag,
        input  ready
    );
    modport sink (
        input  valid, req_type, channel, now_stamp, timeout_value, oneshot_flag, start_flag,
        output ready
    );
endinterface

interface mctm_res_if;
    logic                                valid;
    logic                                ready;
    logic [mctm_pkg::ChanW-1:0]          out_channel;
    logic [mctm_pkg::StampFieldW-1:0]    reset_stamp;
    logic                                fired;
    logic [mctm_pkg::StatusW-1:0]        status;
    logic                                last_result;

    modport source (
        output valid, out_channel, reset_stamp, fired, status, last_result,
        input  ready
    );
    modport sink (
        input  valid, out_channel, reset_stamp, fired, status, last_result,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/mctm_front.sv =====
// Front end: accepts request items, decodes them and registers the command.
`default_nettype none

module mctm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    mctm_req_if.sink            i_req,
    output mctm_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready
);

    logic           r_valid;
    logic           n_valid;
    mctm_pkg::t_cmd r_cmd;
    mctm_pkg::t_cmd n_cmd;
    mctm_pkg::t_op  dec_op;
    logic           accept;

    // The stage takes a new item whenever it is empty or being drained.
    assign i_req.ready = !r_valid || i_cmd_ready;
    assign accept      = i_req.valid && i_req.ready;

    // Request code decode; unknown codes become a no-operation.
    always_comb begin
        case (i_req.req_type)
            mctm_pkg::REQ_TICK:      dec_op = mctm_pkg::OP_TICK;
            mctm_pkg::REQ_ALLOC:     dec_op = mctm_pkg::OP_ALLOC;
            mctm_pkg::REQ_RELEASE:   dec_op = mctm_pkg::OP_RELEASE;
            mctm_pkg::REQ_START:     dec_op = mctm_pkg::OP_START;
            mctm_pkg::REQ_PAUSE:     dec_op = mctm_pkg::OP_PAUSE;
            mctm_pkg::REQ_KICK:      dec_op = mctm_pkg::OP_KICK;
            mctm_pkg::REQ_SET_TMO:   dec_op = mctm_pkg::OP_SET_TMO;
            mctm_pkg::REQ_START_ALL: dec_op = mctm_pkg::OP_START_ALL;
            mctm_pkg::REQ_PAUSE_ALL: dec_op = mctm_pkg::OP_PAUSE_ALL;
            default:                 dec_op = mctm_pkg::OP_NOP;
        endcase
    end

    // Next command and occupancy of the output stage.
    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid            = 1'b1;
            n_cmd.op           = dec_op;
            n_cmd.chan_field   = i_req.channel;
            n_cmd.chan         = mctm_pkg::to_chan(i_req.channel);
            n_cmd.chan_ok      = 32'(i_req.channel) < 32'(mctm_pkg::NUM_CHANNELS);
            n_cmd.now          = mctm_pkg::to_stamp(i_req.now_stamp);
            n_cmd.tmo          = mctm_pkg::to_stamp(i_req.timeout_value);
            n_cmd.oneshot      = i_req.oneshot_flag;
            n_cmd.start        = i_req.start_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

endmodule

`default_nettype wire

// ===== rtl/mctm_queue.sv =====
// Short command queue between the front end and the execution unit.
`default_nettype none

module mctm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mctm_pkg::t_cmd i_cmd,
    input  wire logic           i_valid,
    output logic                o_ready,
    output mctm_pkg::t_cmd      o_cmd,
    output logic                o_valid,
    input  wire logic           i_pop
);

    mctm_pkg::t_cmd                r_mem [mctm_pkg::QueueDepth];
    logic [mctm_pkg::QPtrW-1:0]    r_wr_ptr;
    logic [mctm_pkg::QPtrW-1:0]    r_rd_ptr;
    logic [mctm_pkg::QCntW-1:0]    r_count;
    logic [mctm_pkg::QPtrW-1:0]    n_wr_ptr;
    logic [mctm_pkg::QPtrW-1:0]    n_rd_ptr;
    logic [mctm_pkg::QCntW-1:0]    n_count;
    logic                          push;
    logic                          pop;

    assign o_ready = r_count != mctm_pkg::QCntW'(mctm_pkg::QueueDepth);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    // Pointer and fill count update with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == mctm_pkg::QPtrW'(mctm_pkg::QueueDepth - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == mctm_pkg::QPtrW'(mctm_pkg::QueueDepth - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mctm_back.sv =====
// Execution unit: channel table, tick scan, start-all sweep and result register.
`default_nettype none

module mctm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mctm_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    mctm_res_if.source          o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_EMIT,
        S_FLUSH
    } t_state;

    localparam int N = mctm_pkg::NUM_CHANNELS;

    // Per-channel flags in flip-flops; single-shot is only read once written.
    logic [N-1:0]            r_in_use;
    logic [N-1:0]            r_running;
    logic [N-1:0]            r_single;
    logic [N-1:0]            n_in_use;
    logic [N-1:0]            n_running;
    logic [N-1:0]            n_single;

    // Stamp and limit stores, one write and one registered read each.
    mctm_pkg::t_stamp        r_lim_mem  [N];
    mctm_pkg::t_stamp        r_kick_mem [N];
    mctm_pkg::t_stamp        r_fire_mem [N];
    mctm_pkg::t_stamp        r_lim_rd;
    mctm_pkg::t_stamp        r_kick_rd;
    mctm_pkg::t_stamp        r_fire_rd;

    t_state                  r_state;
    t_state                  n_state;
    mctm_pkg::t_cmd          r_cmd;
    mctm_pkg::t_cmd          n_cmd;
    mctm_pkg::t_chan         r_idx;
    mctm_pkg::t_chan         n_idx;
    logic [mctm_pkg::CntW-1:0] r_nf;
    logic [mctm_pkg::CntW-1:0] n_nf;
    logic                    r_pend_valid;
    logic                    n_pend_valid;
    mctm_pkg::t_res          r_pend;
    mctm_pkg::t_res          n_pend;
    logic                    r_out_valid;
    logic                    n_out_valid;
    mctm_pkg::t_res          r_out;
    mctm_pkg::t_res          n_out;

    mctm_pkg::t_chan         rd_addr;
    logic                    lim_we;
    mctm_pkg::t_chan         lim_wa;
    mctm_pkg::t_stamp        lim_wd;
    logic                    kick_we;
    mctm_pkg::t_chan         kick_wa;
    logic                    fire_we;
    mctm_pkg::t_chan         fire_wa;
    mctm_pkg::t_stamp        stamp_wd;

    logic                    free_found;
    mctm_pkg::t_chan         free_idx;
    logic                    ch_valid;
    logic                    out_free;
    logic                    last_ch;
    logic                    expired;
    mctm_pkg::t_stamp        d_kick;
    mctm_pkg::t_stamp        d_fire;
    mctm_pkg::t_res          res;

    // Lowest free channel for allocation.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_found = 1'b1;
                free_idx   = mctm_pkg::t_chan'(i);
            end
        end
    end

    // Expiry test of the channel under scan; differences wrap at the stamp width.
    assign d_kick   = r_cmd.now - r_kick_rd;
    assign d_fire   = r_cmd.now - r_fire_rd;
    assign expired  = r_in_use[r_idx] && r_running[r_idx] &&
                      (d_kick >= r_lim_rd) && (d_fire >= r_lim_rd);
    assign last_ch  = r_idx == mctm_pkg::t_chan'(N - 1);
    assign ch_valid = i_cmd.chan_ok && r_in_use[i_cmd.chan];
    assign out_free = !r_out_valid || o_res.ready;

    // Command execution and result sequencing.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_nf         = r_nf;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_in_use     = r_in_use;
        n_running    = r_running;
        n_single     = r_single;
        o_cmd_pop    = 1'b0;
        rd_addr      = r_idx;
        lim_we       = 1'b0;
        lim_wa       = i_cmd.chan;
        lim_wd       = i_cmd.tmo;
        kick_we      = 1'b0;
        kick_wa      = i_cmd.chan;
        fire_we      = 1'b0;
        fire_wa      = free_idx;
        stamp_wd     = i_cmd.now;

        res             = '0;
        res.status      = mctm_pkg::ST_OK;
        res.last_result = 1'b1;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == mctm_pkg::OP_TICK) begin
                        o_cmd_pop    = 1'b1;
                        n_cmd        = i_cmd;
                        n_idx        = '0;
                        n_nf         = '0;
                        n_pend_valid = 1'b0;
                        rd_addr      = '0;
                        n_state      = S_SCAN;
                    end else if (i_cmd.op == mctm_pkg::OP_START_ALL) begin
                        o_cmd_pop = 1'b1;
                        n_cmd     = i_cmd;
                        n_running = r_running | r_in_use;
                        n_idx     = '0;
                        n_state   = S_SWEEP;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        case (i_cmd.op)
                            mctm_pkg::OP_ALLOC: begin
                                if (free_found) begin
                                    n_in_use[free_idx]  = 1'b1;
                                    n_running[free_idx] = i_cmd.start;
                                    n_single[free_idx]  = i_cmd.oneshot;
                                    lim_we              = 1'b1;
                                    lim_wa              = free_idx;
                                    kick_we             = 1'b1;
                                    kick_wa             = free_idx;
                                    fire_we             = 1'b1;
                                    res.out_channel     = mctm_pkg::chan_field(free_idx);
                                end else begin
                                    res.status = mctm_pkg::ST_FULL;
                                end
                            end
                            mctm_pkg::OP_RELEASE, mctm_pkg::OP_START, mctm_pkg::OP_PAUSE,
                            mctm_pkg::OP_KICK, mctm_pkg::OP_SET_TMO: begin
                                res.out_channel = i_cmd.chan_field;
                                if (!ch_valid) begin
                                    res.status = mctm_pkg::ST_NOT_IN_USE;
                                end else begin
                                    case (i_cmd.op)
                                        mctm_pkg::OP_RELEASE: begin
                                            n_in_use[i_cmd.chan]  = 1'b0;
                                            n_running[i_cmd.chan] = 1'b0;
                                        end
                                        mctm_pkg::OP_START: begin
                                            n_running[i_cmd.chan] = 1'b1;
                                            kick_we               = 1'b1;
                                        end
                                        mctm_pkg::OP_PAUSE: begin
                                            n_running[i_cmd.chan] = 1'b0;
                                        end
                                        mctm_pkg::OP_KICK: begin
                                            kick_we = 1'b1;
                                        end
                                        default: begin
                                            lim_we = 1'b1;
                                        end
                                    endcase
                                end
                            end
                            mctm_pkg::OP_PAUSE_ALL: begin
                                n_running = r_running & ~r_in_use;
                            end
                            default: begin
                            end
                        endcase
                        n_out_valid = 1'b1;
                        n_out       = res;
                    end
                end
            end

            S_SCAN: begin
                if (!expired) begin
                    if (last_ch) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end else if (!r_pend_valid || out_free) begin
                    // Earlier firing goes out now; this one waits to learn if it is last.
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                    end
                    n_pend_valid       = 1'b1;
                    n_pend.out_channel = mctm_pkg::chan_field(r_idx);
                    n_pend.reset_stamp = mctm_pkg::from_stamp(r_kick_rd);
                    n_pend.fired       = 1'b1;
                    n_pend.status      = mctm_pkg::ST_OK;
                    n_pend.last_result = 1'b0;
                    fire_we            = 1'b1;
                    fire_wa            = r_idx;
                    stamp_wd           = r_cmd.now;
                    if (r_single[r_idx]) begin
                        n_running[r_idx] = 1'b0;
                    end
                    n_nf = r_nf + 1'b1;
                    if (last_ch || r_nf == mctm_pkg::CntW'(mctm_pkg::MaxRes - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out             = r_pend;
                        n_out.last_result = 1'b1;
                    end else begin
                        n_out = res;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            S_SWEEP: begin
                // Start-all moves the kick stamp of every channel in use, one per cycle.
                kick_wa  = r_idx;
                stamp_wd = r_cmd.now;
                kick_we  = r_in_use[r_idx];
                if (last_ch) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table stores with registered read data.
    always_ff @(posedge i_clk) begin
        if (lim_we) begin
            r_lim_mem[lim_wa] <= lim_wd;
        end
        if (kick_we) begin
            r_kick_mem[kick_wa] <= stamp_wd;
        end
        if (fire_we) begin
            r_fire_mem[fire_wa] <= stamp_wd;
        end
        r_lim_rd  <= r_lim_mem[rd_addr];
        r_kick_rd <= r_kick_mem[rd_addr];
        r_fire_rd <= r_fire_mem[rd_addr];
    end

    // State, flags and registered outputs.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_nf     <= n_nf;
        r_pend   <= n_pend;
        r_out    <= n_out;
        r_single <= n_single;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_in_use     <= '0;
            r_running    <= '0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_in_use     <= n_in_use;
            r_running    <= n_running;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_channel = r_out.out_channel;
    assign o_res.reset_stamp = r_out.reset_stamp;
    assign o_res.fired       = r_out.fired;
    assign o_res.status      = r_out.status;
    assign o_res.last_result = r_out.last_result;

endmodule

`default_nettype wire

// ===== rtl/multi_channel_timeout_monitor_core.sv =====
// Top level of the multi-channel timeout monitor: front end, command queue, execution unit.
//
//   Channel  Direction  Handshake     Payload
//   i_req    in         valid/ready   req_type, channel, now_stamp, timeout_value,
//                                     oneshot_flag, start_flag
//   o_res    out        valid/ready   out_channel, reset_stamp, fired, status, last_result
//
// An item is registered in the front stage, passes into the queue and is executed while it
// sits at the head of the queue; a per-channel command, allocate, pause-all or unknown
// request gives its result through the registered result output.
// In a tick the execution unit issues the read of the first channel, visits each channel
// in turn and then gives the final result; a result that waits on a stalled output holds
// the scan. Start-all likewise sweeps the kick stamps channel by channel.
// Synchronous reset clears in-use, running and handshake state; there is no clearing pass.
// The queue lets requests keep arriving while a tick scan or an output stall is under way.
`default_nettype none

module multi_channel_timeout_monitor_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mctm_req_if.sink  i_req,
    mctm_res_if.source o_res
);

    mctm_pkg::t_cmd front_cmd;
    logic           front_valid;
    logic           queue_ready;
    mctm_pkg::t_cmd queue_cmd;
    logic           queue_valid;
    logic           queue_pop;

    // Decode and register incoming items.
    mctm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready)
    );

    // Decouple the front end from the execution unit.
    mctm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid),
        .i_pop   (queue_pop)
    );

    // Execute commands against the channel table.
    mctm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_pop   (queue_pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the multi-channel timeout monitor core.

module tb_top;

    import mctm_pkg::*;

    // Request codes that the block treats as no operation.
    localparam logic [ReqW-1:0] REQ_UNKNOWN_LO = 4'd9;
    localparam logic [ReqW-1:0] REQ_UNKNOWN_HI = 4'd15;

    // Run limits and the settling time once the last result is in.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;

    // One request as the sender presents it.
    typedef struct packed {
        logic [ReqW-1:0]        req_type;
        logic [ChanW-1:0]       channel;
        logic [StampFieldW-1:0] now_stamp;
        logic [StampFieldW-1:0] timeout_value;
        logic                   oneshot_flag;
        logic                   start_flag;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mctm_req_if req_bus ();
    mctm_res_if res_bus ();

    multi_channel_timeout_monitor_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // Free-running clock with a period of four units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the channel table.
    bit     chan_in_use  [NUM_CHANNELS];
    bit     chan_running [NUM_CHANNELS];
    bit     chan_oneshot [NUM_CHANNELS];
    t_stamp chan_limit   [NUM_CHANNELS];
    t_stamp chan_kicked  [NUM_CHANNELS];
    t_stamp chan_fired   [NUM_CHANNELS];

    t_res   pending_results [$];
    t_res   oldest_result;
    t_stamp stamp_now;
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     quiet_tail     = 1'b0;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic t_stamp rand_stamp();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[STAMP_BITS-1:0];
    endfunction

    // A channel expires when it is live, running, and both stamps are at least
    // the timeout old, with differences wrapping at the stamp width.
    function automatic bit chan_expired(input int idx, input t_stamp now_v);
        t_stamp since_kick;
        t_stamp since_fire;
        since_kick = now_v - chan_kicked[idx];
        since_fire = now_v - chan_fired[idx];
        return chan_in_use[idx] && chan_running[idx] &&
               since_kick >= chan_limit[idx] && since_fire >= chan_limit[idx];
    endfunction

    // Apply one request to the shadow table and queue the results it causes.
    function automatic void predict_results(input t_request r);
        t_res   res;
        t_stamp now_v;
        int     ch;
        int     hits [MaxRes];
        int     n;
        int     slot;
        now_v = r.now_stamp;
        ch    = int'(r.channel);
        n     = 0;
        slot  = -1;
        res   = '0;
        res.last_result = 1'b1;
        case (r.req_type)
            REQ_TICK: begin
                for (int i = 0; i < NUM_CHANNELS && n < MaxRes; i++) begin
                    if (chan_expired(i, now_v)) begin
                        hits[n] = i;
                        n++;
                    end
                end
                for (int k = 0; k < n; k++) begin
                    res.out_channel = ChanW'(hits[k]);
                    res.reset_stamp = chan_kicked[hits[k]];
                    res.fired       = 1'b1;
                    res.last_result = (k == n - 1);
                    pending_results.push_back(res);
                    chan_fired[hits[k]] = now_v;
                    if (chan_oneshot[hits[k]]) begin
                        chan_running[hits[k]] = 1'b0;
                    end
                end
                // Nothing expired: a single empty report.
                if (n == 0) begin
                    pending_results.push_back(res);
                end
            end
            REQ_ALLOC: begin
                for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
                    if (!chan_in_use[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    chan_in_use[slot]  = 1'b1;
                    chan_running[slot] = r.start_flag;
                    chan_oneshot[slot] = r.oneshot_flag;
                    chan_limit[slot]   = r.timeout_value;
                    chan_kicked[slot]  = now_v;
                    chan_fired[slot]   = now_v;
                    res.out_channel    = ChanW'(slot);
                end
            end
            REQ_RELEASE, REQ_START, REQ_PAUSE, REQ_KICK, REQ_SET_TMO: begin
                res.out_channel = r.channel;
                if (ch >= NUM_CHANNELS || !chan_in_use[ch]) begin
                    res.status = ST_NOT_IN_USE;
                end else begin
                    case (r.req_type)
                        REQ_RELEASE: begin
                            chan_in_use[ch]  = 1'b0;
                            chan_running[ch] = 1'b0;
                        end
                        REQ_START: begin
                            chan_running[ch] = 1'b1;
                            chan_kicked[ch]  = now_v;
                        end
                        REQ_PAUSE: begin
                            chan_running[ch] = 1'b0;
                        end
                        REQ_KICK: begin
                            chan_kicked[ch] = now_v;
                        end
                        default: begin
                            chan_limit[ch] = r.timeout_value;
                        end
                    endcase
                end
            end
            REQ_START_ALL: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (chan_in_use[i]) begin
                        chan_running[i] = 1'b1;
                        chan_kicked[i]  = now_v;
                    end
                end
            end
            REQ_PAUSE_ALL: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (chan_in_use[i]) begin
                        chan_running[i] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        if (r.req_type != REQ_TICK) begin
            pending_results.push_back(res);
        end
    endfunction

    // Present one item, with an occasional idle burst first, and hold it until taken.
    task automatic send_request(input logic [ReqW-1:0] op, input logic [ChanW-1:0] ch,
                                input t_stamp now_v, input t_stamp tmo_v,
                                input logic os, input logic st);
        t_request r;
        r = '{op, ch, now_v, tmo_v, os, st};
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= r.req_type;
        req_bus.channel       <= r.channel;
        req_bus.now_stamp     <= r.now_stamp;
        req_bus.timeout_value <= r.timeout_value;
        req_bus.oneshot_flag  <= r.oneshot_flag;
        req_bus.start_flag    <= r.start_flag;
        predict_results(r);
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One random item, biased towards live channels and short timeouts so
    // that channels keep expiring.
    task automatic send_random_request();
        logic [ReqW-1:0]  op;
        logic [ChanW-1:0] ch;
        t_stamp           tmo;
        int               pick;
        int               live [$];
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
            op = REQ_TICK;
        end else if (pick < 46) begin
            op = REQ_ALLOC;
        end else if (pick < 56) begin
            op = REQ_RELEASE;
        end else if (pick < 66) begin
            op = REQ_START;
        end else if (pick < 73) begin
            op = REQ_PAUSE;
        end else if (pick < 83) begin
            op = REQ_KICK;
        end else if (pick < 89) begin
            op = REQ_SET_TMO;
        end else if (pick < 93) begin
            op = REQ_START_ALL;
        end else if (pick < 97) begin
            op = REQ_PAUSE_ALL;
        end else begin
            op = ReqW'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        end
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (chan_in_use[i]) begin
                live.push_back(i);
            end
        end
        if (live.size() > 0 && $urandom_range(0, 7) != 0) begin
            ch = ChanW'(live[$urandom_range(0, live.size() - 1)]);
        end else begin
            ch = ChanW'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 15))
            0: tmo = rand_stamp();
            1: tmo = '1 - t_stamp'($urandom_range(0, 3));
            default: tmo = t_stamp'($urandom_range(0, 24));
        endcase
        // Time mostly creeps forward, now and then it jumps anywhere.
        if ($urandom_range(0, 31) == 0) begin
            stamp_now = rand_stamp();
        end else begin
            stamp_now = stamp_now + t_stamp'($urandom_range(0, 6));
        end
        send_request(op, ch, stamp_now, tmo, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    endtask

    // Every operation at least once, the field extremes, stamp wrap and the paused kick.
    task automatic test_directed_ops();
        t_stamp top;
        top = '1;
        send_request(REQ_TICK, 4'd0, 48'd0, 48'd0, 1'b0, 1'b0);
        send_request(REQ_KICK, 4'd15, top, top, 1'b1, 1'b1);
        send_request(REQ_ALLOC, 4'd0, 48'd100, 48'd10, 1'b1, 1'b1);
        send_request(REQ_ALLOC, 4'd7, 48'd100, 48'd0, 1'b0, 1'b0);
        send_request(REQ_ALLOC, 4'd0, 48'd1000, top, 1'b0, 1'b1);
        send_request(REQ_TICK, 4'd0, 48'd105, 48'd0, 1'b0, 1'b0);
        send_request(REQ_START, 4'd1, 48'd106, top, 1'b1, 1'b0);
        send_request(REQ_TICK, 4'd0, 48'd110, 48'd0, 1'b0, 1'b0);
        send_request(REQ_TICK, 4'd0, 48'd110, 48'd0, 1'b0, 1'b0);
        send_request(REQ_PAUSE, 4'd1, 48'd111, 48'd0, 1'b0, 1'b0);
        // A kick on a paused channel still moves its stamp.
        send_request(REQ_KICK, 4'd0, 48'd120, 48'd0, 1'b0, 1'b0);
        send_request(REQ_SET_TMO, 4'd0, 48'd121, 48'd5, 1'b0, 1'b0);
        send_request(REQ_START, 4'd0, 48'd130, 48'd0, 1'b0, 1'b0);
        send_request(REQ_TICK, 4'd0, 48'd135, 48'd0, 1'b0, 1'b0);
        // One tick short of a full wrap meets the largest timeout.
        send_request(REQ_TICK, 4'd0, 48'd999, 48'd0, 1'b0, 1'b0);
        send_request(REQ_START_ALL, 4'd0, top - 48'd3, 48'd0, 1'b0, 1'b0);
        send_request(REQ_TICK, 4'd0, 48'd2, 48'd0, 1'b0, 1'b0);
        send_request(REQ_PAUSE_ALL, 4'd0, 48'd3, 48'd0, 1'b0, 1'b0);
        send_request(REQ_TICK, 4'd0, 48'd50, 48'd0, 1'b0, 1'b0);
        send_request(REQ_UNKNOWN_LO, 4'd3, 48'd51, 48'd0, 1'b0, 1'b0);
        send_request(REQ_UNKNOWN_HI, 4'd15, top, top, 1'b1, 1'b1);
        send_request(REQ_RELEASE, 4'd2, 48'd52, 48'd0, 1'b0, 1'b0);
        send_request(REQ_RELEASE, 4'd2, 48'd53, 48'd0, 1'b0, 1'b0);
        send_request(REQ_SET_TMO, 4'd9, 48'd54, 48'd7, 1'b0, 1'b0);
        send_request(REQ_START, 4'd9, 48'd55, 48'd0, 1'b0, 1'b0);
        send_request(REQ_PAUSE, 4'd9, 48'd56, 48'd0, 1'b0, 1'b0);
        stamp_now = 48'd1000;
    endtask

    // Fill the table past full, fire every channel in one tick, then empty it.
    task automatic test_full_table();
        int offset;
        send_request(REQ_RELEASE, 4'd2, stamp_now, 48'd0, 1'b0, 1'b0);
        repeat (17) begin
            stamp_now = stamp_now + 48'd1;
            send_request(REQ_ALLOC, ChanW'($urandom_range(0, 15)), stamp_now,
                         t_stamp'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b1);
        end
        stamp_now = stamp_now + 48'd1;
        send_request(REQ_START_ALL, 4'd0, stamp_now, 48'd0, 1'b0, 1'b0);
        stamp_now = stamp_now + 48'd8;
        send_request(REQ_TICK, 4'd0, stamp_now, 48'd0, 1'b0, 1'b0);
        send_request(REQ_TICK, 4'd0, stamp_now, 48'd0, 1'b0, 1'b0);
        // Stepping by seven visits every channel once in a shuffled order.
        offset = $urandom_range(0, 15);
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            send_request(REQ_RELEASE, ChanW'((k * 7 + offset) % NUM_CHANNELS),
                         stamp_now, rand_stamp(), 1'b0, 1'b0);
        end
    endtask

    // Random traffic that starts just below the stamp wrap point.
    task automatic test_random_traffic();
        stamp_now = '1 - t_stamp'(150);
        repeat (110) send_random_request();
        wait_for_results();
        repeat (90) send_random_request();
        wait_for_results();
    endtask

    // Last stretch with no idling on either side.
    task automatic test_quiet_tail();
        quiet_tail = 1'b1;
        repeat (60) send_random_request();
    endtask

    // Result side: random stall bursts until the quiet tail.
    initial begin
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Compare each taken result with the oldest one outstanding.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result item with nothing outstanding");
            end else begin
                oldest_result = pending_results.pop_front();
                if (res_bus.out_channel !== oldest_result.out_channel) begin
                    report_mismatch($sformatf("out_channel %0d, wanted %0d",
                        res_bus.out_channel, oldest_result.out_channel));
                end
                if (res_bus.reset_stamp !== oldest_result.reset_stamp) begin
                    report_mismatch($sformatf("reset_stamp %h, wanted %h",
                        res_bus.reset_stamp, oldest_result.reset_stamp));
                end
                if (res_bus.fired !== oldest_result.fired) begin
                    report_mismatch($sformatf("fired %b, wanted %b",
                        res_bus.fired, oldest_result.fired));
                end
                if (res_bus.status !== oldest_result.status) begin
                    report_mismatch($sformatf("status %0d, wanted %0d",
                        res_bus.status, oldest_result.status));
                end
                if (res_bus.last_result !== oldest_result.last_result) begin
                    report_mismatch($sformatf("last_result %b, wanted %b",
                        res_bus.last_result, oldest_result.last_result));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[multi_channel_timeout_monitor_core] ERROR");
            $finish;
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= REQ_TICK;
        req_bus.channel       <= '0;
        req_bus.now_stamp     <= '0;
        req_bus.timeout_value <= '0;
        req_bus.oneshot_flag  <= 1'b0;
        req_bus.start_flag    <= 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_limit[i]  = '0;
            chan_kicked[i] = '0;
            chan_fired[i]  = '0;
        end
        stamp_now = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        wait_for_results();
        test_full_table();
        wait_for_results();
        test_random_traffic();
        test_quiet_tail();
        wait_for_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[multi_channel_timeout_monitor_core] OK");
        end else begin
            $display("[multi_channel_timeout_monitor_core] ERROR");
        end
        $finish;
    end

endmodule
